@@ src/htlp_pkg.sv @@
// ----------------------------------------------------------------------------
// htlp_pkg: shared types and constants for the linear-probe hash table
// Slot geometry, mark and status codes, and the command and status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package htlp_pkg;

  // The home slot is taken from the low key bits, so SLOTS is a power of two.
  localparam int SLOTS        = 16;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int KEY_W        = 31;
  localparam int SLOT_FIELD_W = 4;
  localparam int STATUS_W     = 2;
  localparam int MARK_W       = 2;

  localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request and read its home slot
    logic step;    // move to the next slot
    logic commit;  // update the current slot and report success
    logic fail;    // report full or not found
  } htlp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;   // current slot satisfies the request
    logic stop;  // removal met an empty slot
    logic last;  // current slot is the final one of the walk
  } htlp_sts_t;

endpackage

@@ src/htlp_ctrl.sv @@
// ----------------------------------------------------------------------------
// htlp_ctrl: request sequencer
// Accepts a request, walks the probe sequence one slot per cycle and decides
// when the walk ends in success or failure.
// ----------------------------------------------------------------------------
module htlp_ctrl
  import htlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  htlp_sts_t sts,
  output htlp_cmd_t cmd
);

  localparam logic [0:0] S_IDLE  = 1'b0;
  localparam logic [0:0] S_PROBE = 1'b1;

  logic [0:0] state_r;
  logic [0:0] state_nxt;

  assign busy = (state_r == S_PROBE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        priority if (sts.hit) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.stop || sts.last) begin
          cmd.fail  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/htlp_dpath.sv @@
// ----------------------------------------------------------------------------
// htlp_dpath: slot storage and probe datapath
// Holds the key memory and the slot marks, the probe position and walk
// count, and the registered result.
// ----------------------------------------------------------------------------
module htlp_dpath
  import htlp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  htlp_cmd_t               cmd,
  output htlp_sts_t               sts,
  input  logic                    in_req_type,
  input  logic [KEY_W-1:0]        in_key,
  output logic                    out_valid,
  output logic [STATUS_W-1:0]     out_status,
  output logic [SLOT_FIELD_W-1:0] out_slot
);

  logic [KEY_W-1:0]        key_mem [SLOTS];
  logic [MARK_W-1:0]       marks_r [SLOTS];
  logic [KEY_W-1:0]        rd_key_r;
  logic [KEY_W-1:0]        key_r;
  logic                    req_r;
  logic [SLOT_W-1:0]       pos_r;
  logic [SLOT_W-1:0]       count_r;
  logic [SLOT_W-1:0]       pos_inc;
  logic [SLOT_W-1:0]       rd_addr;
  logic [MARK_W-1:0]       mark_cur;
  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [SLOT_FIELD_W-1:0] out_slot_r;

  assign pos_inc  = (pos_r == SLOT_W'(SLOTS - 1)) ? '0 : pos_r + 1'b1;
  assign rd_addr  = cmd.load ? in_key[SLOT_W-1:0] : pos_inc;
  assign mark_cur = marks_r[pos_r];

  // A key is only trusted when its slot is occupied.
  assign sts.hit  = (req_r == REQ_INSERT) ? (mark_cur != MARK_USED)
                  : ((mark_cur == MARK_USED) && (rd_key_r == key_r));
  assign sts.stop = (req_r == REQ_REMOVE) && (mark_cur == MARK_EMPTY);
  assign sts.last = (count_r == SLOT_W'(SLOTS - 1));

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit && (req_r == REQ_INSERT)) begin
      key_mem[pos_r] <= key_r;
    end
    rd_key_r <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        marks_r[i] <= MARK_EMPTY;
      end
    end else if (cmd.commit) begin
      marks_r[pos_r] <= (req_r == REQ_INSERT) ? MARK_USED : MARK_DELETED;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= in_key;
      req_r   <= in_req_type;
      pos_r   <= in_key[SLOT_W-1:0];
      count_r <= '0;
    end else if (cmd.step) begin
      pos_r   <= pos_inc;
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit || cmd.fail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= (req_r == REQ_INSERT) ? ST_INSERTED : ST_REMOVED;
      out_slot_r   <= SLOT_FIELD_W'(pos_r);
    end else if (cmd.fail) begin
      out_status_r <= (req_r == REQ_INSERT) ? ST_FULL : ST_NOT_FOUND;
      out_slot_r   <= '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

endmodule

@@ src/hash_table_linear_probe.sv @@
// ----------------------------------------------------------------------------
// hash_table_linear_probe: open-addressing hash table with linear probing
// Sixteen-slot table of 31-bit keys with tombstones, serving insert and
// remove requests one at a time.
// ----------------------------------------------------------------------------
// A request is transferred on a rising edge where start is high and busy is
// low. Its home slot is the key modulo the slot count, and the walk then
// examines one slot per clock cycle, so a request keeps busy high until its
// walk ends in success, at an empty slot or after a complete lap; the rate is
// set by the single read port of the key memory, which delivers one stored
// key per cycle. Exactly one result follows each request: out_valid is high
// for one cycle, the first cycle in which busy is low again, and the receiver
// cannot hold it off. A new request may be transferred in that very cycle. Insert takes
// the first empty or deleted slot without looking for duplicates and reports
// full after a complete lap; remove turns the first matching occupied slot
// into a tombstone, giving up at an empty slot or after a complete lap. On a
// failure the slot field reads zero. Reset empties every slot at once; no
// clearing pass is needed, because keys are compared only in occupied slots.
// ----------------------------------------------------------------------------
module hash_table_linear_probe
  import htlp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_req_type,
  input  logic [KEY_W-1:0]        in_key,
  output logic                    out_valid,
  output logic [STATUS_W-1:0]     out_status,
  output logic [SLOT_FIELD_W-1:0] out_slot
);

  // Commands and status between the sequencer and the datapath.
  htlp_cmd_t cmd;
  htlp_sts_t sts;

  // The sequencer owns busy and decides, slot by slot, whether the walk
  // succeeds, fails or carries on.
  htlp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath holds the keys, the marks, the probe position and the
  // result register that presents each transfer for one cycle.
  htlp_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_req_type (in_req_type),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_slot    (out_slot)
  );

endmodule

@@ src/htlp_checker.sv @@
// ----------------------------------------------------------------------------
// htlp_checker: port-level checks for the hash table
// Watches the request and result ports and checks that every request yields
// exactly one well-formed result.
// ----------------------------------------------------------------------------
module htlp_checker
  import htlp_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input logic [STATUS_W-1:0]     out_status,
  input logic [SLOT_FIELD_W-1:0] out_slot
);

  // A transferred request makes the block busy.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request transfer did not raise busy");

  // Busy ends exactly when a result is shown.
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("walk ended without a result");

  // A result only appears at the end of a walk.
  a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(rst_n) && $fell(busy)))
    else $error("result without a preceding walk");

  // A failed request reports slot zero.
  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_NOT_FOUND))
      |-> (out_slot == '0))
    else $error("failed request with non-zero slot");

  // Results are single-cycle strobes.
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

endmodule

bind hash_table_linear_probe htlp_checker u_chk (.*);

@@ dv/htlp_outcome_checker.sv @@
// ----------------------------------------------------------------------------
// htlp_outcome_checker: predicts and checks hash table request outcomes
// Watches the request and result channels of the linear-probe hash table,
// keeps its own copy of the slot table, and compares every result with the
// outcome predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module htlp_outcome_checker
  import htlp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    in_req_type,
  input  logic [KEY_W-1:0]        in_key,
  input  logic                    out_valid,
  input  logic [STATUS_W-1:0]     out_status,
  input  logic [SLOT_FIELD_W-1:0] out_slot,
  output int                      failures,
  output int                      pending,
  output int                      n_inserted,
  output int                      n_full,
  output int                      n_removed,
  output int                      n_not_found
);

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [SLOT_FIELD_W-1:0] slot;
  } outcome_t;

  logic [KEY_W-1:0]  table_keys  [SLOTS];
  logic [MARK_W-1:0] table_marks [SLOTS];
  outcome_t          expected_outcomes [$];

  // Walks the shadow table from the home slot and applies one request to it.
  function automatic outcome_t resolve_request(input logic req, input logic [KEY_W-1:0] key);
    outcome_t res;
    int       pos;
    int       n;
    logic     done;
    res.status = (req == REQ_INSERT) ? ST_FULL : ST_NOT_FOUND;
    res.slot   = '0;
    pos        = int'(key % SLOTS);
    done       = 1'b0;
    for (n = 0; n < SLOTS && !done; n++) begin
      if (req == REQ_INSERT) begin
        if (table_marks[pos] != MARK_USED) begin
          table_keys[pos]  = key;
          table_marks[pos] = MARK_USED;
          res.status       = ST_INSERTED;
          res.slot         = pos[SLOT_FIELD_W-1:0];
          done             = 1'b1;
        end
      end else if (table_marks[pos] == MARK_USED && table_keys[pos] == key) begin
        table_marks[pos] = MARK_DELETED;
        res.status       = ST_REMOVED;
        res.slot         = pos[SLOT_FIELD_W-1:0];
        done             = 1'b1;
      end else if (table_marks[pos] == MARK_EMPTY) begin
        done = 1'b1;
      end
      pos = (pos + 1) % SLOTS;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    int       i;
    if (!rst_n) begin
      for (i = 0; i < SLOTS; i++) table_marks[i] = MARK_EMPTY;
      expected_outcomes.delete();
    end else begin
      // The result of the previous request is retired before a request
      // transferred at the same edge is predicted.
      if (out_valid) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no request outstanding: status %0d slot %0d",
                 out_status, out_slot);
          failures++;
        end else begin
          want = expected_outcomes.pop_front();
          if (out_status !== want.status) begin
            $error("out_status mismatch: expected %0d, got %0d", want.status, out_status);
            failures++;
          end
          if (out_slot !== want.slot) begin
            $error("out_slot mismatch: expected %0d, got %0d", want.slot, out_slot);
            failures++;
          end
          case (want.status)
            ST_INSERTED: n_inserted++;
            ST_FULL:     n_full++;
            ST_REMOVED:  n_removed++;
            default:     n_not_found++;
          endcase
        end
      end
      if (start && !busy) expected_outcomes.push_back(resolve_request(in_req_type, in_key));
    end
    pending = expected_outcomes.size();
  end

endmodule

@@ dv/hash_table_linear_probe_tb.sv @@
// ----------------------------------------------------------------------------
// hash_table_linear_probe_tb: testbench for the linear-probe hash table
// Drives a directed sequence of inserts and removes that walks the table
// through wrap-round, tombstone reuse, full and not-found walks, followed by
// three random phases with different sender idling. A separate checker
// predicts every outcome and counts mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module hash_table_linear_probe_tb
  import htlp_pkg::*;
();

  // Longest run of cycles without any transfer before the run is abandoned.
  // A correct block ends every walk within one lap of the table, and the
  // sender's idle gap comes on top of that.
  localparam int QUIET_LIMIT = 2000;

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    start       = 1'b0;
  logic                    in_req_type = REQ_INSERT;
  logic [KEY_W-1:0]        in_key      = '0;
  logic                    busy;
  logic                    out_valid;
  logic [STATUS_W-1:0]     out_status;
  logic [SLOT_FIELD_W-1:0] out_slot;

  int failures, pending;
  int n_inserted, n_full, n_removed, n_not_found;

  // Percentage of request slots in which the sender holds back.
  int idle_pct = 0;
  int n_insert_reqs = 0;
  int n_remove_reqs = 0;

  // Keys that are probably still in the table, so that removes often hit.
  // It is only a stimulus aid: the checker keeps the real picture.
  logic [KEY_W-1:0] live_keys [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hash_table_linear_probe dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_slot    (out_slot)
  );

  htlp_outcome_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_slot    (out_slot),
    .failures    (failures),
    .pending     (pending),
    .n_inserted  (n_inserted),
    .n_full      (n_full),
    .n_removed   (n_removed),
    .n_not_found (n_not_found)
  );

  // Builds a key with the given home slot. The upper bits are either tiny, so
  // that the same keys come back often, or fully random, so that every key
  // bit is exercised in both directions.
  function automatic logic [KEY_W-1:0] make_key(input int home);
    logic [KEY_W-SLOT_W-1:0] upper;
    if ($urandom_range(0, 1) == 0) begin
      upper = (KEY_W - SLOT_W)'($urandom_range(0, 3));
    end else begin
      upper = (KEY_W - SLOT_W)'($urandom);
    end
    return {upper, home[SLOT_W-1:0]};
  endfunction

  // Presents one request and returns at the edge at which it is transferred.
  // All drives happen at a rising edge, and start is written once per edge:
  // an idle gap lowers it, otherwise it stays high into the next request.
  task automatic send_request(input logic req, input logic [KEY_W-1:0] key);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_key      <= key;
    if (req == REQ_INSERT) n_insert_reqs++;
    else n_remove_reqs++;
    // The transfer happens at the first edge at which busy is low.
    do @(posedge clk); while (busy);
  endtask

  // A random phase. Every forty requests the mix of inserts and removes and a
  // cluster of home slots are chosen afresh, so the table swings between
  // nearly empty and full and the probe walks grow long and wrap round.
  task automatic run_phase(input int sender_idle, input int items);
    int               bias;
    int               cluster;
    int               idx;
    int               n;
    logic [KEY_W-1:0] key;
    idle_pct = sender_idle;
    bias     = 50;
    cluster  = 0;
    for (n = 0; n < items; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       bias = 15;
          1:       bias = 50;
          default: bias = 85;
        endcase
        cluster = $urandom_range(0, SLOTS - 1);
      end
      if ($urandom_range(0, 99) < 5) begin
        // Noise: a fully random key with a random request type.
        key = KEY_W'($urandom);
        send_request(($urandom_range(0, 1) == 1) ? REQ_REMOVE : REQ_INSERT, key);
      end else if ($urandom_range(0, 99) < bias) begin
        if (live_keys.size() != 0 && $urandom_range(0, 99) < 15) begin
          // A duplicate insert: the table must take it again.
          key = live_keys[$urandom_range(0, live_keys.size() - 1)];
        end else if ($urandom_range(0, 99) < 60) begin
          key = make_key((cluster + $urandom_range(0, 3)) % SLOTS);
        end else begin
          key = make_key($urandom_range(0, SLOTS - 1));
        end
        live_keys.push_back(key);
        if (live_keys.size() > 24) live_keys.delete(0);
        send_request(REQ_INSERT, key);
      end else begin
        if (live_keys.size() != 0 && $urandom_range(0, 99) < 70) begin
          idx = $urandom_range(0, live_keys.size() - 1);
          key = live_keys[idx];
          live_keys.delete(idx);
        end else begin
          key = make_key((cluster + $urandom_range(0, 3)) % SLOTS);
        end
        send_request(REQ_REMOVE, key);
      end
    end
  endtask

  // Watchdog: ends the run if no transfer happens on either channel for too
  // long, which is what a hung block or a lost result looks like.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("no transfer for %0d cycles, abandoning the run", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the sender never idling. The extreme keys come
    // first: key zero lands in slot 0, the largest key in the last slot.
    send_request(REQ_INSERT, '0);
    send_request(REQ_INSERT, {KEY_W{1'b1}});
    send_request(REQ_REMOVE, {KEY_W{1'b1}});
    // The last slot is now a tombstone, so this remove skips it, wraps round
    // past the occupied slot 0 and gives up at the empty slot 1.
    send_request(REQ_REMOVE, {KEY_W{1'b1}});
    // A remove whose home slot is empty fails at once.
    send_request(REQ_REMOVE, KEY_W'(5));
    // Fifteen keys sharing home slot 7 fill every free slot: they reuse the
    // tombstone, wrap round past slot 0 and finish in slot 6.
    for (i = 0; i < SLOTS - 1; i++) begin
      send_request(REQ_INSERT, KEY_W'(7 + SLOTS * i));
      live_keys.push_back(KEY_W'(7 + SLOTS * i));
    end
    // With no empty or deleted slot left, an insert walks a full lap and
    // reports a full table, and a remove of an absent key does the same and
    // reports not found.
    send_request(REQ_INSERT, KEY_W'(3));
    send_request(REQ_REMOVE, KEY_W'(7 + SLOTS * 20));
    // Punch a hole at slot 7 and fill it again with a wide key of the same
    // home slot, then clear slot 0.
    send_request(REQ_REMOVE, KEY_W'(7));
    send_request(REQ_INSERT, {{(KEY_W - SLOT_W){1'b1}}, SLOT_W'(7)});
    send_request(REQ_REMOVE, '0);
    live_keys.delete(0);

    // Random part: the sender idles often, then very often, then never.
    run_phase(37, 650);
    run_phase(76, 650);
    run_phase(0, 650);
    start <= 1'b0;

    // Let every outstanding result arrive, then allow one more full walk for
    // anything still on its way. The watchdog bounds the first wait.
    while (pending != 0) @(negedge clk);
    repeat (SLOTS + 4) @(negedge clk);

    $display("Sent %0d inserts and %0d removes; outcomes seen: %0d inserted, %0d full,",
             n_insert_reqs, n_remove_reqs, n_inserted, n_full);
    $display("%0d removed, %0d not found, with %0d mismatches.",
             n_removed, n_not_found, failures);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
